// ----- rtl/pcrqs_pkg.sv -----
// -----------------------------------------------------------------------------
// pcrqs_pkg
// Shared opcodes, result codes, thread states, sequencer states and the
// request and result beat layouts of the per-CPU run queue scheduler.
// -----------------------------------------------------------------------------
package pcrqs_pkg;

    typedef enum logic [2:0] {
        OP_ENQUEUE  = 3'd0,
        OP_DEQUEUE  = 3'd1,
        OP_PREPWAIT = 3'd2,
        OP_WAKEUP   = 3'd3,
        OP_RESCHED  = 3'd4,
        OP_YIELD    = 3'd5
    } op_t;

    localparam logic [1:0] RES_DONE         = 2'd0;
    localparam logic [1:0] RES_WAKE_REFUSED = 2'd1;
    localparam logic [1:0] RES_ENQ_REFUSED  = 2'd2;

    localparam logic [1:0] TS_NEW     = 2'd0;
    localparam logic [1:0] TS_READY   = 2'd1;
    localparam logic [1:0] TS_RUNNING = 2'd2;
    localparam logic [1:0] TS_WAITING = 2'd3;

    localparam logic [7:0] REASON_EINTR = 8'hFC;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_THR_RD,
        ST_UN_START,
        ST_UN_CPU,
        ST_UN_PREV_WR,
        ST_UN_NEXT_WR,
        ST_UN_END,
        ST_AP_CPU,
        ST_AP_TAIL_WR,
        ST_AP_END,
        ST_WK_IPI,
        ST_RS_CUR,
        ST_RS_CURW,
        ST_RS_HEAD,
        ST_SCAN,
        ST_SCAN_CHK,
        ST_TAKE,
        ST_TAKE_END,
        ST_RUN_WR,
        ST_YD_CUR,
        ST_YD_CURW,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        RET_ENQ,
        RET_DEQ,
        RET_WAKE,
        RET_REQ,
        RET_TAKE
    } ret_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [1:0] cpu_id;
        logic [5:0] thread_id;
        logic       interruptible;
        logic [7:0] wake_reason;
        logic       signal_pending;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] thread_out;
        logic       is_idle;
        logic       was_stolen;
        logic       send_ipi;
        logic [1:0] ipi_cpu;
        logic [7:0] reason_out;
        logic       keeps_running;
    } res_t;

endpackage

// ----- rtl/per_cpu_run_queue_scheduler.sv -----
// -----------------------------------------------------------------------------
// per_cpu_run_queue_scheduler
// Thread table with one FIFO run queue per CPU and work stealing.
//
// Each slave beat carries one operation (enqueue, dequeue, prepare-wait,
// wakeup, reschedule, yield); each produces exactly one master beat.
// Thread records and per-CPU queue words live in two RAMs with registered
// reads; a sequencer walks each operation through read, modify and write
// steps, one operation at a time. A reschedule that finds its own queue
// empty scans the other CPUs' queues and steals the tail of the first
// non-empty one. The next beat can be accepted in the cycle after the
// result leaves the sequencer. Each RAM allows one read and one write per
// cycle. After reset the block clears both RAMs with s_tready low. A result
// waits in the output register while m_tready is low; the sequencer then
// holds its finished result and accepts no new beat until the register
// frees up.
// -----------------------------------------------------------------------------
module per_cpu_run_queue_scheduler #(
    parameter int MAX_THREADS = 64,
    parameter int NUM_CPUS    = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cpu_id[1:0], thread_id[7:2], interruptible[8], wake_reason[16:9],
    // signal_pending[17], zero[23:18]
    input  logic [23:0] s_tdata,
    // opcode[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], thread_out[7:2], is_idle[8], was_stolen[9], send_ipi[10],
    // ipi_cpu[12:11], reason_out[20:13], keeps_running[21], zero[23:22]
    output logic [23:0] m_tdata
);

    pcrqs_pkg::req_t req;
    pcrqs_pkg::res_t res;
    logic            res_valid, res_ready;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [23:0]     m_tdata_reg, m_tdata_next;

    always_comb begin
        req.opcode         = s_tuser;
        req.cpu_id         = s_tdata[1:0];
        req.thread_id      = s_tdata[7:2];
        req.interruptible  = s_tdata[8];
        req.wake_reason    = s_tdata[16:9];
        req.signal_pending = s_tdata[17];
    end

    pcrqs_engine #(
        .MAX_THREADS (MAX_THREADS),
        .NUM_CPUS    (NUM_CPUS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req       (req),
        .req_ready (s_tready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, res.keeps_running, res.reason_out, res.ipi_cpu,
                             res.send_ipi, res.was_stolen, res.is_idle,
                             res.thread_out, res.status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/pcrqs_ram.sv -----
// -----------------------------------------------------------------------------
// pcrqs_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// -----------------------------------------------------------------------------
module pcrqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/pcrqs_engine.sv -----
// -----------------------------------------------------------------------------
// pcrqs_engine
// Sequencer that runs each scheduler operation as reads, modifies and writes
// on the thread table RAM and the per-CPU queue RAM.
// -----------------------------------------------------------------------------
module pcrqs_engine #(
    parameter int MAX_THREADS = 64,
    parameter int NUM_CPUS    = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             req_valid,
    input  pcrqs_pkg::req_t  req,
    output logic             req_ready,
    output logic             res_valid,
    output pcrqs_pkg::res_t  res,
    input  logic             res_ready
);

    localparam int TIW       = $clog2(MAX_THREADS + 1);
    localparam int TAW       = $clog2(MAX_THREADS);
    localparam int CIW       = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int CLR_DEPTH = (MAX_THREADS > NUM_CPUS) ? MAX_THREADS : NUM_CPUS;
    localparam int CLW       = $clog2(CLR_DEPTH);
    localparam logic [TIW-1:0] NONE     = TIW'(MAX_THREADS);
    localparam logic [CLW-1:0] CLR_LAST = CLW'(CLR_DEPTH - 1);
    localparam logic [CIW:0]   SCAN_LIM = (CIW + 1)'(NUM_CPUS);

    typedef struct packed {
        logic [1:0]     status;
        logic           intr;
        logic [7:0]     reason;
        logic [CIW-1:0] home;
        logic [TIW-1:0] lnk_prev;
        logic [TIW-1:0] lnk_next;
        logic           inq;
        logic [CIW-1:0] qof;
    } tword_t;

    typedef struct packed {
        logic [TIW-1:0] head;
        logic [TIW-1:0] tail;
        logic [TIW-1:0] run;
    } cword_t;

    localparam int TWW = $bits(tword_t);
    localparam int CWW = $bits(cword_t);

    pcrqs_pkg::state_t state_reg, state_next;
    pcrqs_pkg::ret_t   ret_reg, ret_next;
    pcrqs_pkg::req_t   req_reg, req_next;
    pcrqs_pkg::res_t   res_reg, res_next;
    logic [CIW-1:0]    cpu_reg, cpu_next;
    logic [CIW-1:0]    aq_reg, aq_next;
    logic [TIW-1:0]    t_reg, t_next;
    logic [TIW-1:0]    run_reg, run_next;
    tword_t            tw_reg, tw_next;
    logic              stolen_reg, stolen_next;
    logic [CIW:0]      scan_reg, scan_next;
    logic [CLW-1:0]    clr_reg, clr_next;

    logic           t_we, c_we;
    logic [TAW-1:0] t_waddr, t_raddr;
    logic [CIW-1:0] c_waddr, c_raddr;
    logic [TWW-1:0] t_wdata, t_rdata;
    logic [CWW-1:0] c_wdata, c_rdata;

    tword_t rd_t, wr_t, tw_rst, tw_un;
    cword_t rd_c, wr_c, cw_rst;
    logic   req_ok, wake_refuse, scan_done;

    pcrqs_ram #(.WIDTH(TWW), .DEPTH(MAX_THREADS)) u_thread_ram (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    pcrqs_ram #(.WIDTH(CWW), .DEPTH(NUM_CPUS)) u_cpu_ram (
        .aclk  (aclk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    assign rd_t = t_rdata;
    assign rd_c = c_rdata;

    always_comb begin
        tw_rst          = '0;
        tw_rst.lnk_prev = NONE;
        tw_rst.lnk_next = NONE;
        cw_rst.head     = NONE;
        cw_rst.tail     = NONE;
        cw_rst.run      = NONE;
        tw_un           = tw_reg;
        tw_un.lnk_prev  = NONE;
        tw_un.lnk_next  = NONE;
        tw_un.inq       = 1'b0;
        tw_un.qof       = '0;
    end

    assign req_ok = (req.opcode <= pcrqs_pkg::OP_YIELD) &&
                    (32'(req.cpu_id) < NUM_CPUS) &&
                    ((req.opcode > pcrqs_pkg::OP_WAKEUP) ||
                     (32'(req.thread_id) < MAX_THREADS));

    assign wake_refuse = (rd_t.status != pcrqs_pkg::TS_WAITING) ||
                         ((req_reg.wake_reason != 8'd0) && !rd_t.intr);

    assign scan_done = (scan_reg == SCAN_LIM);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pcrqs_pkg::ST_CLEAR: begin
                if (clr_reg == CLR_LAST) begin
                    state_next = pcrqs_pkg::ST_IDLE;
                end
            end
            pcrqs_pkg::ST_IDLE: begin
                if (req_valid) begin
                    if (!req_ok) begin
                        state_next = pcrqs_pkg::ST_DONE;
                    end else if (req.opcode == pcrqs_pkg::OP_RESCHED) begin
                        state_next = pcrqs_pkg::ST_RS_CUR;
                    end else if (req.opcode == pcrqs_pkg::OP_YIELD) begin
                        state_next = pcrqs_pkg::ST_YD_CUR;
                    end else begin
                        state_next = pcrqs_pkg::ST_THR_RD;
                    end
                end
            end
            pcrqs_pkg::ST_THR_RD: begin
                case (req_reg.opcode)
                    pcrqs_pkg::OP_ENQUEUE: begin
                        state_next = (rd_t.status == pcrqs_pkg::TS_READY) ?
                                     pcrqs_pkg::ST_DONE : pcrqs_pkg::ST_UN_START;
                    end
                    pcrqs_pkg::OP_DEQUEUE: begin
                        state_next = (rd_t.inq && rd_t.qof == cpu_reg) ?
                                     pcrqs_pkg::ST_UN_START : pcrqs_pkg::ST_DONE;
                    end
                    pcrqs_pkg::OP_WAKEUP: begin
                        state_next = wake_refuse ? pcrqs_pkg::ST_DONE :
                                     pcrqs_pkg::ST_UN_START;
                    end
                    default: begin
                        state_next = pcrqs_pkg::ST_DONE;
                    end
                endcase
            end
            pcrqs_pkg::ST_UN_START: begin
                state_next = tw_reg.inq ? pcrqs_pkg::ST_UN_CPU : pcrqs_pkg::ST_UN_END;
            end
            pcrqs_pkg::ST_UN_CPU: begin
                if (tw_reg.lnk_prev != NONE) begin
                    state_next = pcrqs_pkg::ST_UN_PREV_WR;
                end else if (tw_reg.lnk_next != NONE) begin
                    state_next = pcrqs_pkg::ST_UN_NEXT_WR;
                end else begin
                    state_next = pcrqs_pkg::ST_UN_END;
                end
            end
            pcrqs_pkg::ST_UN_PREV_WR: begin
                state_next = (tw_reg.lnk_next != NONE) ? pcrqs_pkg::ST_UN_NEXT_WR :
                             pcrqs_pkg::ST_UN_END;
            end
            pcrqs_pkg::ST_UN_NEXT_WR: begin
                state_next = pcrqs_pkg::ST_UN_END;
            end
            pcrqs_pkg::ST_UN_END: begin
                case (ret_reg)
                    pcrqs_pkg::RET_DEQ:  state_next = pcrqs_pkg::ST_DONE;
                    pcrqs_pkg::RET_TAKE: state_next = pcrqs_pkg::ST_TAKE_END;
                    default:             state_next = pcrqs_pkg::ST_AP_CPU;
                endcase
            end
            pcrqs_pkg::ST_AP_CPU: begin
                state_next = (rd_c.tail != NONE) ? pcrqs_pkg::ST_AP_TAIL_WR :
                             pcrqs_pkg::ST_AP_END;
            end
            pcrqs_pkg::ST_AP_TAIL_WR: begin
                state_next = pcrqs_pkg::ST_AP_END;
            end
            pcrqs_pkg::ST_AP_END: begin
                case (ret_reg)
                    pcrqs_pkg::RET_ENQ:  state_next = pcrqs_pkg::ST_DONE;
                    pcrqs_pkg::RET_WAKE: state_next = pcrqs_pkg::ST_WK_IPI;
                    default:             state_next = pcrqs_pkg::ST_RS_HEAD;
                endcase
            end
            pcrqs_pkg::ST_WK_IPI: begin
                state_next = pcrqs_pkg::ST_DONE;
            end
            pcrqs_pkg::ST_RS_CUR: begin
                state_next = (rd_c.run != NONE) ? pcrqs_pkg::ST_RS_CURW :
                             pcrqs_pkg::ST_RS_HEAD;
            end
            pcrqs_pkg::ST_RS_CURW: begin
                state_next = (rd_t.status == pcrqs_pkg::TS_RUNNING) ?
                             pcrqs_pkg::ST_UN_START : pcrqs_pkg::ST_RS_HEAD;
            end
            pcrqs_pkg::ST_RS_HEAD: begin
                state_next = (rd_c.head != NONE) ? pcrqs_pkg::ST_TAKE : pcrqs_pkg::ST_SCAN;
            end
            pcrqs_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = pcrqs_pkg::ST_RUN_WR;
                end else if (scan_reg[CIW-1:0] != cpu_reg) begin
                    state_next = pcrqs_pkg::ST_SCAN_CHK;
                end
            end
            pcrqs_pkg::ST_SCAN_CHK: begin
                state_next = (rd_c.tail != NONE) ? pcrqs_pkg::ST_TAKE : pcrqs_pkg::ST_SCAN;
            end
            pcrqs_pkg::ST_TAKE: begin
                state_next = pcrqs_pkg::ST_UN_START;
            end
            pcrqs_pkg::ST_TAKE_END: begin
                state_next = pcrqs_pkg::ST_RUN_WR;
            end
            pcrqs_pkg::ST_RUN_WR: begin
                state_next = pcrqs_pkg::ST_DONE;
            end
            pcrqs_pkg::ST_YD_CUR: begin
                state_next = (rd_c.run == NONE) ? pcrqs_pkg::ST_DONE : pcrqs_pkg::ST_YD_CURW;
            end
            pcrqs_pkg::ST_YD_CURW: begin
                if (rd_t.status != pcrqs_pkg::TS_WAITING ||
                    (rd_t.intr && req_reg.signal_pending)) begin
                    state_next = pcrqs_pkg::ST_DONE;
                end else begin
                    state_next = pcrqs_pkg::ST_RS_HEAD;
                end
            end
            pcrqs_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = pcrqs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pcrqs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ret_next    = ret_reg;
        req_next    = req_reg;
        res_next    = res_reg;
        cpu_next    = cpu_reg;
        aq_next     = aq_reg;
        t_next      = t_reg;
        run_next    = run_reg;
        tw_next     = tw_reg;
        stolen_next = stolen_reg;
        scan_next   = scan_reg;
        clr_next    = clr_reg;
        req_ready   = 1'b0;
        res_valid   = 1'b0;
        t_we        = 1'b0;
        t_waddr     = t_reg[TAW-1:0];
        t_wdata     = tw_reg;
        t_raddr     = t_reg[TAW-1:0];
        c_we        = 1'b0;
        c_waddr     = cpu_reg;
        c_wdata     = rd_c;
        c_raddr     = cpu_reg;
        wr_t        = rd_t;
        wr_c        = rd_c;
        case (state_reg)
            pcrqs_pkg::ST_CLEAR: begin
                t_we     = (32'(clr_reg) < MAX_THREADS);
                t_waddr  = clr_reg[TAW-1:0];
                t_wdata  = tw_rst;
                c_we     = (32'(clr_reg) < NUM_CPUS);
                c_waddr  = clr_reg[CIW-1:0];
                c_wdata  = cw_rst;
                clr_next = clr_reg + 1'b1;
            end
            pcrqs_pkg::ST_IDLE: begin
                req_ready = 1'b1;
                t_raddr   = TAW'(req.thread_id);
                c_raddr   = CIW'(req.cpu_id);
                if (req_valid) begin
                    req_next = req;
                    cpu_next = CIW'(req.cpu_id);
                    t_next   = TIW'(req.thread_id);
                    res_next = '0;
                end
            end
            pcrqs_pkg::ST_THR_RD: begin
                tw_next = rd_t;
                case (req_reg.opcode)
                    pcrqs_pkg::OP_ENQUEUE: begin
                        if (rd_t.status == pcrqs_pkg::TS_READY) begin
                            res_next.status     = pcrqs_pkg::RES_ENQ_REFUSED;
                            res_next.reason_out = rd_t.reason;
                        end else begin
                            tw_next.status = pcrqs_pkg::TS_READY;
                            aq_next        = cpu_reg;
                            ret_next       = pcrqs_pkg::RET_ENQ;
                        end
                    end
                    pcrqs_pkg::OP_DEQUEUE: begin
                        ret_next            = pcrqs_pkg::RET_DEQ;
                        res_next.reason_out = rd_t.reason;
                    end
                    pcrqs_pkg::OP_PREPWAIT: begin
                        wr_t.status = pcrqs_pkg::TS_WAITING;
                        wr_t.intr   = rd_t.intr | req_reg.interruptible;
                        wr_t.reason = '0;
                        t_we        = 1'b1;
                        t_wdata     = wr_t;
                    end
                    pcrqs_pkg::OP_WAKEUP: begin
                        if (wake_refuse) begin
                            res_next.status     = pcrqs_pkg::RES_WAKE_REFUSED;
                            res_next.reason_out = rd_t.reason;
                        end else begin
                            tw_next.status = pcrqs_pkg::TS_READY;
                            tw_next.intr   = 1'b0;
                            tw_next.reason = req_reg.wake_reason;
                            aq_next        = rd_t.home;
                            ret_next       = pcrqs_pkg::RET_WAKE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            pcrqs_pkg::ST_UN_START: begin
                c_raddr = tw_reg.qof;
            end
            pcrqs_pkg::ST_UN_CPU: begin
                if (tw_reg.lnk_prev == NONE) begin
                    wr_c.head = tw_reg.lnk_next;
                end
                if (tw_reg.lnk_next == NONE) begin
                    wr_c.tail = tw_reg.lnk_prev;
                end
                c_we    = 1'b1;
                c_waddr = tw_reg.qof;
                c_wdata = wr_c;
                t_raddr = (tw_reg.lnk_prev != NONE) ? tw_reg.lnk_prev[TAW-1:0] :
                          tw_reg.lnk_next[TAW-1:0];
            end
            pcrqs_pkg::ST_UN_PREV_WR: begin
                wr_t.lnk_next = tw_reg.lnk_next;
                t_we          = 1'b1;
                t_waddr       = tw_reg.lnk_prev[TAW-1:0];
                t_wdata       = wr_t;
                if (tw_reg.lnk_next != NONE) begin
                    t_raddr = tw_reg.lnk_next[TAW-1:0];
                end
            end
            pcrqs_pkg::ST_UN_NEXT_WR: begin
                wr_t.lnk_prev = tw_reg.lnk_prev;
                t_we          = 1'b1;
                t_waddr       = tw_reg.lnk_next[TAW-1:0];
                t_wdata       = wr_t;
            end
            pcrqs_pkg::ST_UN_END: begin
                tw_next = tw_un;
                c_raddr = aq_reg;
                if (ret_reg == pcrqs_pkg::RET_DEQ) begin
                    t_we    = 1'b1;
                    t_wdata = tw_un;
                end
            end
            pcrqs_pkg::ST_AP_CPU: begin
                tw_next.lnk_prev = rd_c.tail;
                tw_next.lnk_next = NONE;
                tw_next.inq      = 1'b1;
                tw_next.qof      = aq_reg;
                if (rd_c.tail == NONE) begin
                    wr_c.head = t_reg;
                end
                wr_c.tail = t_reg;
                c_we      = 1'b1;
                c_waddr   = aq_reg;
                c_wdata   = wr_c;
                t_raddr   = rd_c.tail[TAW-1:0];
            end
            pcrqs_pkg::ST_AP_TAIL_WR: begin
                wr_t.lnk_next = t_reg;
                t_we          = 1'b1;
                t_waddr       = tw_reg.lnk_prev[TAW-1:0];
                t_wdata       = wr_t;
            end
            pcrqs_pkg::ST_AP_END: begin
                t_we                = 1'b1;
                t_wdata             = tw_reg;
                res_next.reason_out = tw_reg.reason;
                c_raddr             = (ret_reg == pcrqs_pkg::RET_WAKE) ? aq_reg : cpu_reg;
            end
            pcrqs_pkg::ST_WK_IPI: begin
                if (aq_reg != cpu_reg && rd_c.run != NONE) begin
                    res_next.send_ipi = 1'b1;
                    res_next.ipi_cpu  = 2'(aq_reg);
                end
            end
            pcrqs_pkg::ST_RS_CUR: begin
                t_next  = rd_c.run;
                t_raddr = rd_c.run[TAW-1:0];
            end
            pcrqs_pkg::ST_RS_CURW: begin
                tw_next        = rd_t;
                tw_next.status = pcrqs_pkg::TS_READY;
                aq_next        = rd_t.home;
                ret_next       = pcrqs_pkg::RET_REQ;
            end
            pcrqs_pkg::ST_RS_HEAD: begin
                t_next      = rd_c.head;
                t_raddr     = rd_c.head[TAW-1:0];
                stolen_next = 1'b0;
                scan_next   = '0;
            end
            pcrqs_pkg::ST_SCAN: begin
                c_raddr = scan_reg[CIW-1:0];
                if (scan_done) begin
                    run_next          = NONE;
                    res_next.is_idle  = 1'b1;
                    c_raddr           = cpu_reg;
                end else if (scan_reg[CIW-1:0] == cpu_reg) begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            pcrqs_pkg::ST_SCAN_CHK: begin
                t_next      = rd_c.tail;
                t_raddr     = rd_c.tail[TAW-1:0];
                stolen_next = 1'b1;
                scan_next   = scan_reg + 1'b1;
            end
            pcrqs_pkg::ST_TAKE: begin
                tw_next  = rd_t;
                ret_next = pcrqs_pkg::RET_TAKE;
            end
            pcrqs_pkg::ST_TAKE_END: begin
                wr_t        = tw_reg;
                wr_t.status = pcrqs_pkg::TS_RUNNING;
                if (stolen_reg) begin
                    wr_t.home = cpu_reg;
                end
                t_we                = 1'b1;
                t_wdata             = wr_t;
                run_next            = t_reg;
                res_next.thread_out = 6'(t_reg);
                res_next.was_stolen = stolen_reg;
                res_next.reason_out = tw_reg.reason;
            end
            pcrqs_pkg::ST_RUN_WR: begin
                wr_c.run = run_reg;
                c_we     = 1'b1;
                c_wdata  = wr_c;
            end
            pcrqs_pkg::ST_YD_CUR: begin
                t_next  = rd_c.run;
                t_raddr = rd_c.run[TAW-1:0];
                if (rd_c.run == NONE) begin
                    res_next.is_idle       = 1'b1;
                    res_next.keeps_running = 1'b1;
                end
            end
            pcrqs_pkg::ST_YD_CURW: begin
                if (rd_t.status != pcrqs_pkg::TS_WAITING) begin
                    res_next.thread_out    = 6'(t_reg);
                    res_next.reason_out    = rd_t.reason;
                    res_next.keeps_running = 1'b1;
                end else if (rd_t.intr && req_reg.signal_pending) begin
                    wr_t.status            = pcrqs_pkg::TS_RUNNING;
                    wr_t.intr              = 1'b0;
                    wr_t.reason            = pcrqs_pkg::REASON_EINTR;
                    t_we                   = 1'b1;
                    t_wdata                = wr_t;
                    res_next.thread_out    = 6'(t_reg);
                    res_next.reason_out    = pcrqs_pkg::REASON_EINTR;
                    res_next.keeps_running = 1'b1;
                end
            end
            pcrqs_pkg::ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= pcrqs_pkg::ST_CLEAR;
            clr_reg    <= '0;
            ret_reg    <= pcrqs_pkg::RET_ENQ;
            stolen_reg <= 1'b0;
            scan_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ret_reg    <= ret_next;
            stolen_reg <= stolen_next;
            scan_reg   <= scan_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        res_reg <= res_next;
        cpu_reg <= cpu_next;
        aq_reg  <= aq_next;
        t_reg   <= t_next;
        run_reg <= run_next;
        tw_reg  <= tw_next;
    end

    assign res = res_reg;

    a_thread_rw_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        (t_we && state_reg != pcrqs_pkg::ST_CLEAR && state_reg != pcrqs_pkg::ST_IDLE)
        |-> (t_waddr != t_raddr || state_reg == pcrqs_pkg::ST_THR_RD ||
             state_reg == pcrqs_pkg::ST_UN_END || state_reg == pcrqs_pkg::ST_AP_END ||
             state_reg == pcrqs_pkg::ST_TAKE_END || state_reg == pcrqs_pkg::ST_YD_CURW ||
             state_reg == pcrqs_pkg::ST_UN_NEXT_WR || state_reg == pcrqs_pkg::ST_AP_TAIL_WR))
        else $error("thread RAM read and write collide");

    a_idle_no_thread: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_reg.is_idle) |-> (res_reg.thread_out == 6'd0 && !res_reg.was_stolen))
        else $error("idle result carries a thread");

    a_ipi_on_wakeup: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_reg.send_ipi)
        |-> (req_reg.opcode == pcrqs_pkg::OP_WAKEUP && res_reg.status == pcrqs_pkg::RES_DONE))
        else $error("IPI outside an accepted wakeup");

    a_keeps_on_yield: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_reg.keeps_running) |-> (req_reg.opcode == pcrqs_pkg::OP_YIELD))
        else $error("keeps_running outside yield");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_reg)))
        else $error("result changed while stalled");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Drives scheduler operations into per_cpu_run_queue_scheduler over the
// request stream, predicts every result beat with a behavioral model of the
// thread table and per-CPU run queues, and checks each whole beat against it.
// Runs directed cases, then random traffic under several idle/stall phases.
// -----------------------------------------------------------------------------
module testbench;

    localparam int NTHR = 64;
    localparam int NCPU = 4;
    localparam int NIL  = NTHR;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] cpu;
        logic [5:0] tid;
        logic       intr;
        logic [7:0] reason;
        logic       sig;
    } sched_op_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        s_tready_seen;

    per_cpu_run_queue_scheduler dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // scheduler model state
    logic [1:0] thr_state [NTHR];
    logic       thr_intr  [NTHR];
    logic [7:0] thr_reason[NTHR];
    logic [1:0] thr_home  [NTHR];
    int         lprev     [NTHR];
    int         lnext     [NTHR];
    logic       queued    [NTHR];
    int         qof       [NTHR];
    int         qhead     [NCPU];
    int         qtail     [NCPU];
    int         running   [NCPU];

    sched_op_t            pending_ops[$];
    pcrqs_pkg::res_t      expected_res[$];
    int                   errors;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   hold_off;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    task automatic unlink_thr(input int t);
        int p;
        int n;
        int q;
        if (!queued[t]) return;
        q = qof[t];
        p = lprev[t];
        n = lnext[t];
        if (p != NIL) lnext[p] = n; else qhead[q] = n;
        if (n != NIL) lprev[n] = p; else qtail[q] = p;
        lprev[t] = NIL;
        lnext[t] = NIL;
        queued[t] = 1'b0;
        qof[t] = 0;
    endtask

    task automatic append_thr(input int q, input int t);
        int tl;
        unlink_thr(t);
        tl = qtail[q];
        lprev[t] = tl;
        lnext[t] = NIL;
        if (tl != NIL) lnext[tl] = t; else qhead[q] = t;
        qtail[q] = t;
        queued[t] = 1'b1;
        qof[t] = q;
    endtask

    task automatic pick_next(input int c, inout pcrqs_pkg::res_t r);
        int cur;
        int nxt;
        logic stolen;
        cur = running[c];
        stolen = 1'b0;
        if (cur != NIL && thr_state[cur] == pcrqs_pkg::TS_RUNNING) begin
            thr_state[cur] = pcrqs_pkg::TS_READY;
            append_thr(int'(thr_home[cur]), cur);
        end
        nxt = qhead[c];
        if (nxt == NIL) begin
            for (int i = 0; i < NCPU; i++) begin
                if (i != c && qtail[i] != NIL) begin
                    nxt = qtail[i];
                    stolen = 1'b1;
                    break;
                end
            end
        end
        if (nxt != NIL) begin
            unlink_thr(nxt);
            if (stolen) thr_home[nxt] = c[1:0];
            thr_state[nxt] = pcrqs_pkg::TS_RUNNING;
            running[c] = nxt;
            r.thread_out = nxt[5:0];
            r.was_stolen = stolen;
            r.reason_out = thr_reason[nxt];
        end else begin
            running[c] = NIL;
            r.is_idle = 1'b1;
        end
    endtask

    task automatic schedule_op(input sched_op_t o);
        pcrqs_pkg::res_t r;
        int c;
        int t;
        int cur;
        int h;
        r = '0;
        c = int'(o.cpu);
        t = int'(o.tid);
        if (o.op <= 3'd5) begin
            case (pcrqs_pkg::op_t'(o.op))
                pcrqs_pkg::OP_ENQUEUE: begin
                    if (thr_state[t] == pcrqs_pkg::TS_READY) begin
                        r.status = pcrqs_pkg::RES_ENQ_REFUSED;
                    end else begin
                        thr_state[t] = pcrqs_pkg::TS_READY;
                        append_thr(c, t);
                    end
                    r.reason_out = thr_reason[t];
                end
                pcrqs_pkg::OP_DEQUEUE: begin
                    if (queued[t] && qof[t] == c) unlink_thr(t);
                    r.reason_out = thr_reason[t];
                end
                pcrqs_pkg::OP_PREPWAIT: begin
                    thr_state[t] = pcrqs_pkg::TS_WAITING;
                    thr_intr[t] = thr_intr[t] | o.intr;
                    thr_reason[t] = '0;
                end
                pcrqs_pkg::OP_WAKEUP: begin
                    if (thr_state[t] != pcrqs_pkg::TS_WAITING ||
                        (o.reason != 8'd0 && !thr_intr[t])) begin
                        r.status = pcrqs_pkg::RES_WAKE_REFUSED;
                    end else begin
                        h = int'(thr_home[t]);
                        thr_state[t] = pcrqs_pkg::TS_READY;
                        thr_intr[t] = 1'b0;
                        thr_reason[t] = o.reason;
                        append_thr(h, t);
                        if (h != c && running[h] != NIL) begin
                            r.send_ipi = 1'b1;
                            r.ipi_cpu = h[1:0];
                        end
                    end
                    r.reason_out = thr_reason[t];
                end
                pcrqs_pkg::OP_RESCHED: pick_next(c, r);
                pcrqs_pkg::OP_YIELD: begin
                    cur = running[c];
                    if (cur == NIL) begin
                        r.is_idle = 1'b1;
                        r.keeps_running = 1'b1;
                    end else if (thr_state[cur] != pcrqs_pkg::TS_WAITING) begin
                        r.thread_out = cur[5:0];
                        r.reason_out = thr_reason[cur];
                        r.keeps_running = 1'b1;
                    end else if (thr_intr[cur] && o.sig) begin
                        thr_state[cur] = pcrqs_pkg::TS_RUNNING;
                        thr_intr[cur] = 1'b0;
                        thr_reason[cur] = pcrqs_pkg::REASON_EINTR;
                        r.thread_out = cur[5:0];
                        r.reason_out = pcrqs_pkg::REASON_EINTR;
                        r.keeps_running = 1'b1;
                    end else begin
                        pick_next(c, r);
                    end
                end
                default: ;
            endcase
        end
        expected_res.push_back(r);
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready_seen) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                sched_op_t o;
                o = pending_ops.pop_front();
                s_tuser  <= o.op;
                s_tdata  <= {6'b0, o.sig, o.reason, o.intr, o.tid, o.cpu};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        s_tready_seen <= 1'b0;
        if (aresetn && s_tvalid && s_tready) begin
            s_tready_seen <= 1'b1;
            schedule_op({s_tuser, s_tdata[1:0], s_tdata[7:2], s_tdata[8],
                         s_tdata[16:9], s_tdata[17]});
        end
    end

    // receiver ready
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_res.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_tdata);
                errors++;
            end else begin
                pcrqs_pkg::res_t e;
                pcrqs_pkg::res_t a;
                e = expected_res.pop_front();
                a = {m_tdata[1:0], m_tdata[7:2], m_tdata[8], m_tdata[9], m_tdata[10],
                     m_tdata[12:11], m_tdata[20:13], m_tdata[21]};
                if (a != e || m_tdata[23:22] != 2'b0) begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, a);
                    errors++;
                end
            end
        end
    end

    function automatic sched_op_t rand_op();
        sched_op_t o;
        int k;
        o.cpu    = 2'($urandom_range(3));
        o.tid    = 6'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(11));
        o.intr   = 1'($urandom_range(1));
        o.reason = ($urandom_range(2) == 0) ? 8'($urandom_range(255)) : 8'd0;
        o.sig    = 1'($urandom_range(1));
        k = $urandom_range(99);
        if (k < 2) o.op = 3'(6 + $urandom_range(1));
        else if (k < 24) o.op = pcrqs_pkg::OP_ENQUEUE;
        else if (k < 32) o.op = pcrqs_pkg::OP_DEQUEUE;
        else if (k < 50) o.op = pcrqs_pkg::OP_PREPWAIT;
        else if (k < 68) o.op = pcrqs_pkg::OP_WAKEUP;
        else if (k < 86) o.op = pcrqs_pkg::OP_RESCHED;
        else o.op = pcrqs_pkg::OP_YIELD;
        return o;
    endfunction

    task automatic wait_drained();
        while (pending_ops.size() > 0 || s_tvalid || expected_res.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        sched_op_t o;
        errors = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < NTHR; i++) begin
            thr_state[i] = pcrqs_pkg::TS_NEW; thr_intr[i] = '0; thr_reason[i] = '0;
            thr_home[i] = '0;
            lprev[i] = NIL; lnext[i] = NIL; queued[i] = '0; qof[i] = 0;
        end
        for (int i = 0; i < NCPU; i++) begin
            qhead[i] = NIL; qtail[i] = NIL; running[i] = NIL;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        pending_ops.push_back('{pcrqs_pkg::OP_YIELD, 2'd0, 6'd0, 1'b0, 8'd0, 1'b0});
        pending_ops.push_back('{pcrqs_pkg::OP_RESCHED, 2'd3, 6'd0, 1'b0, 8'd0, 1'b0});
        pending_ops.push_back('{pcrqs_pkg::OP_ENQUEUE, 2'd1, 6'd63, 1'b1, 8'hFF, 1'b1});
        pending_ops.push_back('{pcrqs_pkg::OP_ENQUEUE, 2'd1, 6'd63, 1'b0, 8'd0, 1'b0});
        pending_ops.push_back('{pcrqs_pkg::OP_ENQUEUE, 2'd1, 6'd0, 1'b0, 8'd0, 1'b0});
        pending_ops.push_back('{pcrqs_pkg::OP_DEQUEUE, 2'd2, 6'd0, 1'b0, 8'd0, 1'b0});
        pending_ops.push_back('{pcrqs_pkg::OP_RESCHED, 2'd0, 6'd0, 1'b0, 8'd0, 1'b0});
        pending_ops.push_back('{pcrqs_pkg::OP_PREPWAIT, 2'd0, 6'd0, 1'b1, 8'd0, 1'b0});
        pending_ops.push_back('{pcrqs_pkg::OP_YIELD, 2'd0, 6'd0, 1'b0, 8'd0, 1'b1});
        pending_ops.push_back('{pcrqs_pkg::OP_PREPWAIT, 2'd0, 6'd0, 1'b0, 8'd0, 1'b0});
        pending_ops.push_back('{pcrqs_pkg::OP_YIELD, 2'd0, 6'd0, 1'b0, 8'd0, 1'b0});
        pending_ops.push_back('{pcrqs_pkg::OP_WAKEUP, 2'd1, 6'd0, 1'b0, 8'h80, 1'b0});
        pending_ops.push_back('{pcrqs_pkg::OP_WAKEUP, 2'd1, 6'd5, 1'b0, 8'd0, 1'b0});
        pending_ops.push_back('{pcrqs_pkg::OP_PREPWAIT, 2'd2, 6'd5, 1'b0, 8'd0, 1'b0});
        pending_ops.push_back('{pcrqs_pkg::OP_WAKEUP, 2'd2, 6'd5, 1'b0, 8'h7F, 1'b0});
        pending_ops.push_back('{pcrqs_pkg::OP_WAKEUP, 2'd2, 6'd5, 1'b0, 8'd0, 1'b0});
        pending_ops.push_back('{pcrqs_pkg::OP_ENQUEUE, 2'd2, 6'd0, 1'b0, 8'd0, 1'b0});
        pending_ops.push_back('{pcrqs_pkg::OP_RESCHED, 2'd3, 6'd0, 1'b0, 8'd0, 1'b0});
        pending_ops.push_back('{3'd6, 2'd0, 6'd1, 1'b0, 8'd0, 1'b0});
        pending_ops.push_back('{3'd7, 2'd3, 6'd63, 1'b1, 8'hFF, 1'b1});
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                3: begin send_idle_pct = 21; recv_stall_pct = 21; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4) begin
                @(negedge aclk);
                hold_off = 300;
            end
            for (int i = 0; i < 340; i++) begin
                o = rand_op();
                pending_ops.push_back(o);
            end
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        if (errors == 0 && expected_res.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/pcrqs_pkg.sv
rtl/pcrqs_ram.sv
rtl/pcrqs_engine.sv
rtl/per_cpu_run_queue_scheduler.sv
verif/testbench.sv
